>>> hw/rtl/bmap_pkg.sv
package bmap_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TUNE_X        = 3'd0,
    REG_TUNE_Y        = 3'd1,
    REG_CHROMA_X      = 3'd2,
    REG_CHROMA_Y      = 3'd3,
    REG_COUPLING_GAIN = 3'd4,
    REG_SEXT_NORMAL   = 3'd5,
    REG_SEXT_SKEW     = 3'd6
  } cfg_reg_e;

  // Quadrant of the phase, from its top two bits
  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_e;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned LIN_W     = 35;  // rotated momentum before kicks
  localparam int unsigned ACC_W     = 41;  // momentum plus coupling kick
  localparam int unsigned TERM_W    = 46;  // rounded sextupole terms
  localparam int unsigned FULL_W    = 96;  // 64 x 32 product
  localparam int unsigned SUM_W     = 48;  // final momentum sum

  localparam logic [63:0] INV_TWO_PI_Q64 = 64'h28BE60DB9391054A;
  localparam logic [63:0] GAIN_Q32       = 64'h000000009B74EDA8;

  // atan(2^-idx)/(2 pi) in Q0.64 turns; evaluated at elaboration only
  function automatic logic [63:0] cordic_angle(input int idx);
    logic [63:0]  sum;
    logic [63:0]  term;
    logic [64:0]  rem;
    logic [127:0] prod;
    int           e;
    int           n;
    sum = '0;
    if (idx == 0) begin
      return 64'h2000000000000000;
    end
    for (int k = 0; idx * (2 * k + 1) <= 64; k++) begin
      e    = 64 - idx * (2 * k + 1);
      n    = 2 * k + 1;
      // floor(2^e / n) by restoring long division
      rem  = '0;
      term = '0;
      for (int b = 63; b >= 0; b--) begin
        rem = {rem[63:0], (b == e) ? 1'b1 : 1'b0};
        if (rem >= 65'(n)) begin
          rem     = rem - 65'(n);
          term[b] = 1'b1;
        end
      end
      if (k[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    prod = 128'(sum) * 128'(INV_TWO_PI_Q64);
    return prod[127:64];
  endfunction

  // CORDIC start value K scaled to w-2 fraction bits
  function automatic logic [63:0] cordic_gain(input int w);
    if (w - 2 <= 32) begin
      return GAIN_Q32 >> (32 - (w - 2));
    end
    return GAIN_Q32 << ((w - 2) - 32);
  endfunction

  // v / 2^sh rounded half away from zero
  function automatic logic signed [127:0] round_shift(input logic signed [127:0] v,
                                                      input int unsigned sh);
    logic signed [127:0] half;
    logic signed [127:0] bias;
    half = 128'sd1 <<< (sh - 1);
    bias = v[127] ? half - 128'sd1 : half;
    return (v + bias) >>> sh;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end
    if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic ovf32(input logic signed [63:0] v);
    return (v > 64'sd2147483647) || (v < -64'sd2147483648);
  endfunction

endpackage

>>> hw/rtl/betatron_turn_map.sv
// One-turn transverse map for a stream of particles.
// Input channel: in_valid_i / in_stall_o with fields pos_x, mom_x, pos_y,
// mom_y and deviation; a beat moves when valid is high and stall is low.
// Output channel: out_valid_o / out_stall_i with the rotated and kicked
// coordinates and a saturated flag, one result beat per input beat, in order.
// Throughput: one particle per cycle while the output is not stalled.
// Pipeline: the chain of CORDIC cells (one micro-rotation per cell and
// cycle), the product and phase stages ahead of it, the fold, rotate and
// round stages after it, and six kick stages including the output register.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_data_i; write only
// while no beat is in flight. Unknown indexes are ignored.
// Reset clears the registers and empties the pipeline.
// When the receiver stalls a valid result, the whole pipeline holds and
// in_stall_o rises in the same cycle; nothing is dropped.
module betatron_turn_map #(
  parameter int WORD_WIDTH    = 32,
  parameter int CORDIC_STAGES = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bmap_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [31:0]                pos_x_i,
  input  logic signed [31:0]                mom_x_i,
  input  logic signed [31:0]                pos_y_i,
  input  logic signed [31:0]                mom_y_i,
  input  logic signed [31:0]                deviation_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [31:0]                new_pos_x_o,
  output logic signed [31:0]                new_mom_x_o,
  output logic signed [31:0]                new_pos_y_o,
  output logic signed [31:0]                new_mom_y_o,
  output logic                              saturated_o
);

  localparam int LAT = CORDIC_STAGES + 11;

  // configuration registers
  logic [31:0]        tune_x_q, tune_y_q;
  logic signed [31:0] chroma_x_q, chroma_y_q, gain_q, kn_q, ks_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tune_x_q   <= '0;
      tune_y_q   <= '0;
      chroma_x_q <= '0;
      chroma_y_q <= '0;
      gain_q     <= '0;
      kn_q       <= '0;
      ks_q       <= '0;
    end else if (cfg_we_i) begin
      case (bmap_pkg::cfg_reg_e'(cfg_idx_i))
        bmap_pkg::REG_TUNE_X:        tune_x_q   <= cfg_data_i;
        bmap_pkg::REG_TUNE_Y:        tune_y_q   <= cfg_data_i;
        bmap_pkg::REG_CHROMA_X:      chroma_x_q <= cfg_data_i;
        bmap_pkg::REG_CHROMA_Y:      chroma_y_q <= cfg_data_i;
        bmap_pkg::REG_COUPLING_GAIN: gain_q     <= cfg_data_i;
        bmap_pkg::REG_SEXT_NORMAL:   kn_q       <= cfg_data_i;
        bmap_pkg::REG_SEXT_SKEW:     ks_q       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // pipeline advance and valid tracking
  logic           en;
  logic [LAT-1:0] vld_d, vld_q;

  assign en         = !(vld_q[LAT-1] && out_stall_i);
  assign in_stall_o = !en;
  assign vld_d      = {vld_q[LAT-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  // both planes
  logic signed [31:0]                nx, ny;
  logic signed [bmap_pkg::LIN_W-1:0] nmx, nmy;
  logic                              sat_x, sat_y;

  bmap_plane #(
    .W (WORD_WIDTH),
    .N (CORDIC_STAGES)
  ) u_plane_x (
    .clk_i     (clk_i),
    .en_i      (en),
    .tune_i    (tune_x_q),
    .chroma_i  (chroma_x_q),
    .dev_i     (deviation_i),
    .pos_i     (pos_x_i),
    .mom_i     (mom_x_i),
    .new_pos_o (nx),
    .new_mom_o (nmx),
    .sat_o     (sat_x)
  );

  bmap_plane #(
    .W (WORD_WIDTH),
    .N (CORDIC_STAGES)
  ) u_plane_y (
    .clk_i     (clk_i),
    .en_i      (en),
    .tune_i    (tune_y_q),
    .chroma_i  (chroma_y_q),
    .dev_i     (deviation_i),
    .pos_i     (pos_y_i),
    .mom_i     (mom_y_i),
    .new_pos_o (ny),
    .new_mom_o (nmy),
    .sat_o     (sat_y)
  );

  // coupling and sextupole kicks, output register
  bmap_kick u_kick (
    .clk_i   (clk_i),
    .en_i    (en),
    .nx_i    (nx),
    .ny_i    (ny),
    .nmx_i   (nmx),
    .nmy_i   (nmy),
    .sat_i   (sat_x | sat_y),
    .gain_i  (gain_q),
    .kn_i    (kn_q),
    .ks_i    (ks_q),
    .pos_x_o (new_pos_x_o),
    .mom_x_o (new_mom_x_o),
    .pos_y_o (new_pos_y_o),
    .mom_y_o (new_mom_y_o),
    .sat_o   (saturated_o)
  );

  assign out_valid_o = vld_q[LAT-1];

`ifndef SYNTHESIS
  // a frozen pipeline keeps its occupancy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  // the flag implies some output sits at a rail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |->
      (new_pos_x_o == 32'sh7fffffff || new_pos_x_o == 32'sh80000000 ||
       new_mom_x_o == 32'sh7fffffff || new_mom_x_o == 32'sh80000000 ||
       new_pos_y_o == 32'sh7fffffff || new_pos_y_o == 32'sh80000000 ||
       new_mom_y_o == 32'sh7fffffff || new_mom_y_o == 32'sh80000000))
    else $error("saturated flag without a clipped output");
`endif

endmodule

>>> hw/rtl/bmap_cordic_cell.sv
module bmap_cordic_cell #(
  parameter int W   = 32,
  parameter int IDX = 0
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [W-1:0]    x_i,
  input  logic signed [W-1:0]    y_i,
  input  logic signed [63:0]     z_i,
  input  bmap_pkg::quad_e        q_i,
  input  logic signed [31:0]     p_i,
  input  logic signed [31:0]     m_i,
  output logic signed [W-1:0]    x_o,
  output logic signed [W-1:0]    y_o,
  output logic signed [63:0]     z_o,
  output bmap_pkg::quad_e        q_o,
  output logic signed [31:0]     p_o,
  output logic signed [31:0]     m_o
);

  localparam logic signed [63:0] ANGLE = $signed(bmap_pkg::cordic_angle(IDX));

  logic signed [W-1:0] xs, ys;
  logic signed [W-1:0] x_d, y_d, x_q, y_q;
  logic signed [63:0]  z_d, z_q;
  bmap_pkg::quad_e     q_q;
  logic signed [31:0]  p_q, m_q;

  assign xs = x_i >>> IDX;
  assign ys = y_i >>> IDX;

  // one micro-rotation, direction from the residual angle sign
  always_comb begin
    if (!z_i[63]) begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - ANGLE;
    end else begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + ANGLE;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
      q_q <= q_i;
      p_q <= p_i;
      m_q <= m_i;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;
  assign q_o = q_q;
  assign p_o = p_q;
  assign m_o = m_q;

endmodule

>>> hw/rtl/bmap_plane.sv
module bmap_plane #(
  parameter int W = 32,
  parameter int N = 24
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic        [31:0]                   tune_i,
  input  logic signed [31:0]                   chroma_i,
  input  logic signed [31:0]                   dev_i,
  input  logic signed [31:0]                   pos_i,
  input  logic signed [31:0]                   mom_i,
  output logic signed [31:0]                   new_pos_o,
  output logic signed [bmap_pkg::LIN_W-1:0]    new_mom_o,
  output logic                                 sat_o
);

  localparam int FRAC = W - 2;
  localparam logic signed [W-1:0] X_INIT = W'(bmap_pkg::cordic_gain(W));

  // chromatic phase product
  logic signed [63:0] prod_q;
  logic signed [31:0] p0_p_q, p0_m_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= chroma_i * dev_i;
      p0_p_q <= pos_i;
      p0_m_q <= mom_i;
    end
  end

  // phase in Q0.64 turns, wraps modulo one turn
  logic [63:0]        phase_d;
  logic signed [63:0] z0_q;
  bmap_pkg::quad_e    q0_q;
  logic signed [31:0] p1_p_q, p1_m_q;

  assign phase_d = {tune_i, 32'd0} + ($unsigned(prod_q) << 12);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      z0_q   <= $signed({2'b00, phase_d[61:0]});
      q0_q   <= bmap_pkg::quad_e'(phase_d[63:62]);
      p1_p_q <= p0_p_q;
      p1_m_q <= p0_m_q;
    end
  end

  // CORDIC chain
  logic signed [W-1:0] x_c [0:N];
  logic signed [W-1:0] y_c [0:N];
  logic signed [63:0]  z_c [0:N];
  bmap_pkg::quad_e     q_c [0:N];
  logic signed [31:0]  p_c [0:N];
  logic signed [31:0]  m_c [0:N];

  assign x_c[0] = X_INIT;
  assign y_c[0] = '0;
  assign z_c[0] = z0_q;
  assign q_c[0] = q0_q;
  assign p_c[0] = p1_p_q;
  assign m_c[0] = p1_m_q;

  for (genvar i = 0; i < N; i++) begin : g_cell
    bmap_cordic_cell #(
      .W   (W),
      .IDX (i)
    ) u_cell (
      .clk_i (clk_i),
      .en_i  (en_i),
      .x_i   (x_c[i]),
      .y_i   (y_c[i]),
      .z_i   (z_c[i]),
      .q_i   (q_c[i]),
      .p_i   (p_c[i]),
      .m_i   (m_c[i]),
      .x_o   (x_c[i+1]),
      .y_o   (y_c[i+1]),
      .z_o   (z_c[i+1]),
      .q_o   (q_c[i+1]),
      .p_o   (p_c[i+1]),
      .m_o   (m_c[i+1])
    );
  end

  // rescale to Q.30
  logic signed [31:0] cx30, sy30;

  if (FRAC > 30) begin : g_rnd
    localparam logic signed [W-1:0] RND = W'(64'd1 << (FRAC - 31));
    logic signed [W-1:0] cx_r, sy_r;
    assign cx_r = (x_c[N] + RND) >>> (FRAC - 30);
    assign sy_r = (y_c[N] + RND) >>> (FRAC - 30);
    assign cx30 = 32'(cx_r);
    assign sy30 = 32'(sy_r);
  end else begin : g_scl
    assign cx30 = 32'(x_c[N]) <<< (30 - FRAC);
    assign sy30 = 32'(y_c[N]) <<< (30 - FRAC);
  end

  // quadrant fold
  logic signed [31:0] c_d, s_d, c_q, s_q, p2_p_q, p2_m_q;

  always_comb begin
    case (q_c[N])
      bmap_pkg::QUAD_I: begin
        c_d = cx30;
        s_d = sy30;
      end
      bmap_pkg::QUAD_II: begin
        c_d = -sy30;
        s_d = cx30;
      end
      bmap_pkg::QUAD_III: begin
        c_d = -cx30;
        s_d = -sy30;
      end
      default: begin
        c_d = sy30;
        s_d = -cx30;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_q    <= c_d;
      s_q    <= s_d;
      p2_p_q <= p_c[N];
      p2_m_q <= m_c[N];
    end
  end

  // rotation products
  logic signed [63:0] pc_q, ms_q, mc_q, ps_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pc_q <= p2_p_q * c_q;
      ms_q <= p2_m_q * s_q;
      mc_q <= p2_m_q * c_q;
      ps_q <= p2_p_q * s_q;
    end
  end

  // round, sum, saturate position; momentum difference
  logic signed [63:0] rpc, rms, rmc, rps, pos_sum;
  logic signed [31:0] new_pos_q;
  logic signed [bmap_pkg::LIN_W-1:0] new_mom_q;
  logic sat_q;

  assign rpc     = 64'(bmap_pkg::round_shift(128'(pc_q), 30));
  assign rms     = 64'(bmap_pkg::round_shift(128'(ms_q), 30));
  assign rmc     = 64'(bmap_pkg::round_shift(128'(mc_q), 30));
  assign rps     = 64'(bmap_pkg::round_shift(128'(ps_q), 30));
  assign pos_sum = rpc + rms;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      new_pos_q <= bmap_pkg::sat32(pos_sum);
      sat_q     <= bmap_pkg::ovf32(pos_sum);
      new_mom_q <= bmap_pkg::LIN_W'(rmc - rps);
    end
  end

  assign new_pos_o = new_pos_q;
  assign new_mom_o = new_mom_q;
  assign sat_o     = sat_q;

endmodule

>>> hw/rtl/bmap_kick.sv
module bmap_kick (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [31:0]                nx_i,
  input  logic signed [31:0]                ny_i,
  input  logic signed [bmap_pkg::LIN_W-1:0] nmx_i,
  input  logic signed [bmap_pkg::LIN_W-1:0] nmy_i,
  input  logic                              sat_i,
  input  logic signed [31:0]                gain_i,
  input  logic signed [31:0]                kn_i,
  input  logic signed [31:0]                ks_i,
  output logic signed [31:0]                pos_x_o,
  output logic signed [31:0]                mom_x_o,
  output logic signed [31:0]                pos_y_o,
  output logic signed [31:0]                mom_y_o,
  output logic                              sat_o
);

  localparam int unsigned LW = bmap_pkg::LIN_W;
  localparam int unsigned AW = bmap_pkg::ACC_W;
  localparam int unsigned TW = bmap_pkg::TERM_W;
  localparam int unsigned FW = bmap_pkg::FULL_W;
  localparam int unsigned SW = bmap_pkg::SUM_W;

  // K1: squares, cross term, coupling products
  logic signed [63:0] xx_q, yy_q, xy1_q, gy_q, gx_q;
  logic signed [31:0] nx1_q, ny1_q;
  logic signed [LW-1:0] mx1_q, my1_q;
  logic sat1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xx_q   <= nx_i * nx_i;
      yy_q   <= ny_i * ny_i;
      xy1_q  <= nx_i * ny_i;
      gy_q   <= ny_i * gain_i;
      gx_q   <= nx_i * gain_i;
      nx1_q  <= nx_i;
      ny1_q  <= ny_i;
      mx1_q  <= nmx_i;
      my1_q  <= nmy_i;
      sat1_q <= sat_i;
    end
  end

  // K2: x^2 - y^2 and coupling kick
  logic signed [63:0] sq_q, xy2_q;
  logic signed [AW-1:0] accx2_q, accy2_q;
  logic signed [31:0] nx2_q, ny2_q;
  logic sat2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q    <= xx_q - yy_q;
      xy2_q   <= xy1_q;
      accx2_q <= AW'(mx1_q) + AW'(bmap_pkg::round_shift(128'(gy_q), 24));
      accy2_q <= AW'(my1_q) + AW'(bmap_pkg::round_shift(128'(gx_q), 24));
      nx2_q   <= nx1_q;
      ny2_q   <= ny1_q;
      sat2_q  <= sat1_q;
    end
  end

  // K3: 64 x 32 products as high and low partial products
  logic signed [63:0] sqn_hi_q, sqs_hi_q, xyn_hi_q, xys_hi_q;
  logic signed [64:0] sqn_lo_q, sqs_lo_q, xyn_lo_q, xys_lo_q;
  logic signed [AW-1:0] accx3_q, accy3_q;
  logic signed [31:0] nx3_q, ny3_q;
  logic sat3_q;
  logic signed [32:0] sq_lo, xy_lo;
  logic signed [31:0] sq_hi, xy_hi;

  assign sq_hi = sq_q[63:32];
  assign xy_hi = xy2_q[63:32];
  assign sq_lo = $signed({1'b0, sq_q[31:0]});
  assign xy_lo = $signed({1'b0, xy2_q[31:0]});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqn_hi_q <= sq_hi * kn_i;
      sqs_hi_q <= sq_hi * ks_i;
      xyn_hi_q <= xy_hi * kn_i;
      xys_hi_q <= xy_hi * ks_i;
      sqn_lo_q <= sq_lo * kn_i;
      sqs_lo_q <= sq_lo * ks_i;
      xyn_lo_q <= xy_lo * kn_i;
      xys_lo_q <= xy_lo * ks_i;
      accx3_q  <= accx2_q;
      accy3_q  <= accy2_q;
      nx3_q    <= nx2_q;
      ny3_q    <= ny2_q;
      sat3_q   <= sat2_q;
    end
  end

  // K4: combine partial products
  logic signed [FW-1:0] sqn_q, sqs_q, xyn_q, xys_q;
  logic signed [AW-1:0] accx4_q, accy4_q;
  logic signed [31:0] nx4_q, ny4_q;
  logic sat4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sqn_q   <= (FW'(sqn_hi_q) <<< 32) + FW'(sqn_lo_q);
      sqs_q   <= (FW'(sqs_hi_q) <<< 32) + FW'(sqs_lo_q);
      xyn_q   <= (FW'(xyn_hi_q) <<< 32) + FW'(xyn_lo_q);
      xys_q   <= (FW'(xys_hi_q) <<< 32) + FW'(xys_lo_q);
      accx4_q <= accx3_q;
      accy4_q <= accy3_q;
      nx4_q   <= nx3_q;
      ny4_q   <= ny3_q;
      sat4_q  <= sat3_q;
    end
  end

  // K5: round sextupole terms; halves of Kn and Ks fold into the shift
  logic signed [TW-1:0] t_sqn_q, t_sqs_q, t_xyn_q, t_xys_q;
  logic signed [AW-1:0] accx5_q, accy5_q;
  logic signed [31:0] nx5_q, ny5_q;
  logic sat5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_sqn_q <= TW'(bmap_pkg::round_shift(128'(sqn_q), 53));
      t_sqs_q <= TW'(bmap_pkg::round_shift(128'(sqs_q), 53));
      t_xyn_q <= TW'(bmap_pkg::round_shift(128'(xyn_q), 52));
      t_xys_q <= TW'(bmap_pkg::round_shift(128'(xys_q), 52));
      accx5_q <= accx4_q;
      accy5_q <= accy4_q;
      nx5_q   <= nx4_q;
      ny5_q   <= ny4_q;
      sat5_q  <= sat4_q;
    end
  end

  // K6: final sums, saturate, output register
  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [31:0] pos_x_q, mom_x_q, pos_y_q, mom_y_q;
  logic sat_q;

  assign sum_x = SW'(accx5_q) + SW'(t_sqn_q) - SW'(t_xys_q);
  assign sum_y = SW'(accy5_q) + SW'(t_sqs_q) + SW'(t_xyn_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pos_x_q <= nx5_q;
      pos_y_q <= ny5_q;
      mom_x_q <= bmap_pkg::sat32(64'(sum_x));
      mom_y_q <= bmap_pkg::sat32(64'(sum_y));
      sat_q   <= sat5_q | bmap_pkg::ovf32(64'(sum_x)) | bmap_pkg::ovf32(64'(sum_y));
    end
  end

  assign pos_x_o = pos_x_q;
  assign mom_x_o = mom_x_q;
  assign pos_y_o = pos_y_q;
  assign mom_y_o = mom_y_q;
  assign sat_o   = sat_q;

endmodule
